// ===== hw/rtl/linear_fit_gradient_descent_macros.svh =====
// Assertion macros for the line-fit block.
`ifndef LINEAR_FIT_GRADIENT_DESCENT_MACROS_SVH
`define LINEAR_FIT_GRADIENT_DESCENT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define LFGD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LFGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lfgd_pkg.sv =====
package lfgd_pkg;
    localparam int unsigned MaxPointsDefault = 256;
    localparam int unsigned XW = 32;
    localparam int unsigned EW = 40;
    localparam int unsigned IW = 11;
    localparam logic [IW-1:0] MaxIterReset = 11'd100;
    localparam logic [30:0] ThreshReset = 31'd655;
    localparam logic [15:0] RateReset = 16'd1311;
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_MAX_ITER = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_THRESH = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_RATE = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ITER_START,
        ST_READ,
        ST_MUL1,
        ST_PRED,
        ST_MUL2,
        ST_ACC,
        ST_STEP_MUL,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } fit_state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctrl_t;

    function automatic logic signed [XW-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh7FFF_FFFF;
        lo = -64'sh8000_0000;
        if (v > hi) return 32'sh7FFF_FFFF;
        else if (v < lo) return -32'sh8000_0000;
        else return v[XW-1:0];
    endfunction

    function automatic logic signed [EW-1:0] sat40(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh7F_FFFF_FFFF;
        lo = -64'sh80_0000_0000;
        if (v > hi) return 40'sh7F_FFFF_FFFF;
        else if (v < lo) return -40'sh80_0000_0000;
        else return v[EW-1:0];
    endfunction
endpackage

// ===== hw/rtl/lfgd_if.sv =====
interface lfgd_point_if;
    logic valid;
    logic ready;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic last_point;
    modport source (output valid, x_value, y_value, last_point, input ready);
    modport sink (input valid, x_value, y_value, last_point, output ready);
endinterface

interface lfgd_result_if;
    logic valid;
    logic ready;
    logic signed [31:0] fit_offset;
    logic signed [31:0] fit_slope;
    logic signed [39:0] final_error;
    logic [10:0] iterations_used;
    modport source (output valid, fit_offset, fit_slope, final_error, iterations_used,
                    input ready);
    modport sink (input valid, fit_offset, fit_slope, final_error, iterations_used,
                  output ready);
endinterface

interface lfgd_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lfgd_store.sv =====
module lfgd_store
    import lfgd_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MaxPointsDefault,
    parameter int unsigned AW = $clog2(MAX_POINTS)
) (
    input  logic clk,
    input  logic wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic signed [XW-1:0] wr_x,
    input  logic signed [XW-1:0] wr_y,
    input  logic [AW-1:0] rd_addr,
    output logic signed [XW-1:0] rd_x,
    output logic signed [XW-1:0] rd_y
);
    logic [2*XW-1:0] mem [MAX_POINTS];
    logic [2*XW-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_x = rd_reg[2*XW-1:XW];
    assign rd_y = rd_reg[XW-1:0];
endmodule

// ===== hw/rtl/lfgd_divider.sv =====
module lfgd_divider
    import lfgd_pkg::*;
#(
    parameter int unsigned NW = 57,
    parameter int unsigned DW = 25
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic [NW-1:0] quot,
    output div_ctrl_t ctrl
);
    // restoring divider, one quotient bit a cycle
    localparam int unsigned CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0] r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [DW:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = '0;
        if (start)
        begin
            q_next = numer;
            r_next = '0;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg[DW-1:0], q_reg[NW-1]};
            q_next = {q_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, denom})
            begin
                r_next = trial - {1'b0, denom};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign quot = q_reg;
    assign ctrl.start = start;
    assign ctrl.busy = busy_reg;
endmodule

// ===== hw/rtl/linear_fit_gradient_descent.sv =====
// Line fit by batch gradient descent, Q16.16 fixed point.
// Channels: pts (sink) takes one (x_value, y_value, last_point) word per
// cycle while loading; res (source) gives one word per set: fit_offset,
// fit_slope, final_error, iterations_used; cfg (sink) writes max_iterations
// (index 0), stop_threshold (1) and learning_rate (2); the user must write
// them only while the block idles, which the block itself leaves unchecked.
// Points go into a dual-field synchronous RAM of MAX_POINTS entries; past
// that, points are dropped but last_point still starts the fit. The word
// with last_point starts the fit; pts.ready is low until the result has
// been handed over. One iteration walks the RAM with one point in flight:
// it is opened, each point is read, passes two registered multiplies and
// is accumulated, then the step products, two serial divides and update
// run; the single multiplier path and shared bit-serial divider set its pace.
// Reset clears the point count, the estimates and the registers to their
// defaults; the RAM is not cleared. A stalled result holds until taken.
`include "linear_fit_gradient_descent_macros.svh"
module linear_fit_gradient_descent
    import lfgd_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MaxPointsDefault
) (
    input  logic clk,
    input  logic rst_n,
    lfgd_point_if.sink pts,
    lfgd_result_if.source res,
    lfgd_cfg_if.sink cfg
);
    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);
    localparam int unsigned NUMW = 57;
    localparam int unsigned DENW = CNTW + 16;

    fit_state_t state_reg, state_next;

    logic [IW-1:0] max_iter_reg;
    logic [30:0] thresh_reg;
    logic [15:0] rate_reg;

    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] idx_reg, idx_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic signed [XW-1:0] off_reg, off_next;
    logic signed [XW-1:0] slope_reg, slope_next;
    logic signed [63:0] acc_e_reg, acc_e_next;
    logic signed [63:0] acc_g_reg, acc_g_next;
    logic signed [EW-1:0] esum_reg, esum_next;
    logic signed [EW-1:0] grad_reg;
    logic signed [63:0] prod_reg;
    logic signed [XW-1:0] err_reg;
    logic signed [XW-1:0] xh_reg;
    logic signed [XW-1:0] yh_reg;
    logic signed [63:0] stp_e_reg, stp_g_reg;
    logic div_second_reg;
    logic signed [NUMW-1:0] d0_reg;
    logic done_reg;
    logic out_valid_reg;

    logic signed [XW-1:0] rd_x, rd_y;
    logic wr_en;
    logic div_start;
    logic [NUMW-1:0] div_numer;
    logic [NUMW-1:0] div_quot;
    div_ctrl_t div_ctrl;
    logic signed [63:0] pred;
    logic signed [NUMW-1:0] d1_val;
    logic [EW-1:0] esum_mag;
    logic [IW-1:0] limit;

    // ---- configuration: always ready, taken only when idle by contract
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MaxIterReset;
            thresh_reg <= ThreshReset;
            rate_reg <= RateReset;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MAX_ITER: max_iter_reg <= cfg.data[IW-1:0];
                CFG_THRESH:   thresh_reg <= cfg.data[30:0];
                CFG_RATE:     rate_reg <= cfg.data[15:0];
                default:      ;
            endcase
        end
    end

    // ---- point store
    assign pts.ready = (state_reg == ST_LOAD);
    assign wr_en = pts.valid && pts.ready && (count_reg < CNTW'(MAX_POINTS));

    lfgd_store #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_store (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(count_reg[AW-1:0]),
        .wr_x(pts.x_value),
        .wr_y(pts.y_value),
        .rd_addr(idx_reg[AW-1:0]),
        .rd_x(rd_x),
        .rd_y(rd_y)
    );

    // ---- step divider, shared by offset and slope steps
    assign div_numer = div_second_reg ? NUMW'(stp_g_reg < 0 ? -stp_g_reg : stp_g_reg)
                                      : NUMW'(stp_e_reg < 0 ? -stp_e_reg : stp_e_reg);
    lfgd_divider #(.NW(NUMW), .DW(DENW)) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .numer(div_numer),
        .denom({count_reg, 16'd0}),
        .quot(div_quot),
        .ctrl(div_ctrl)
    );

    assign limit = (max_iter_reg == '0) ? IW'(1) : max_iter_reg;
    assign esum_mag = esum_reg[EW-1] ? EW'(-esum_reg) : EW'(esum_reg);
    assign pred = 64'(off_reg) + (prod_reg >>> 16);
    assign d1_val = stp_g_reg[63] ? -$signed(div_quot) : $signed(div_quot);

    // ---- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (pts.valid && pts.last_point) state_next = ST_ITER_START;
            ST_ITER_START: state_next = ST_READ;
            ST_READ:       state_next = ST_MUL1;
            ST_MUL1:       state_next = ST_PRED;
            ST_PRED:       state_next = ST_MUL2;
            ST_MUL2:       state_next = ST_ACC;
            ST_ACC:
                if (idx_reg == count_reg) state_next = ST_STEP_MUL;
                else state_next = ST_READ;
            ST_STEP_MUL:   state_next = ST_DIV;
            ST_DIV:
                if (!div_ctrl.start && !div_ctrl.busy && div_second_reg && done_reg)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                if (esum_mag <= EW'(thresh_reg) || iter_reg >= limit)
                    state_next = ST_OUT;
                else
                    state_next = ST_ITER_START;
            ST_OUT:
                if (res.ready) state_next = ST_LOAD;
            default:       state_next = ST_LOAD;
        endcase
    end

    // ---- datapath next values
    always_comb
    begin
        count_next = count_reg;
        idx_next = idx_reg;
        iter_next = iter_reg;
        off_next = off_reg;
        slope_next = slope_reg;
        acc_e_next = acc_e_reg;
        acc_g_next = acc_g_reg;
        esum_next = esum_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (wr_en) count_next = count_reg + 1'b1;
                if (pts.valid && pts.last_point)
                begin
                    off_next = '0;
                    slope_next = '0;
                    iter_next = '0;
                end
            end
            ST_ITER_START:
            begin
                idx_next = '0;
                acc_e_next = '0;
                acc_g_next = '0;
                iter_next = iter_reg + 1'b1;
            end
            ST_READ: idx_next = idx_reg + 1'b1;
            ST_ACC:
            begin
                acc_e_next = acc_e_reg + 64'(err_reg);
                acc_g_next = acc_g_reg + (prod_reg >>> 16);
            end
            ST_STEP_MUL: esum_next = sat40(acc_e_reg);
            // launch a divide whenever none is running or waiting to be taken
            ST_DIV:
                div_start = !div_ctrl.busy && !done_reg;
            ST_UPDATE:
            begin
                off_next = sat32(64'(off_reg) - 64'(d0_reg));
                slope_next = sat32(64'(slope_reg) - 64'(d1_val));
            end
            ST_OUT:
                if (res.ready) count_next = '0;
            default: ;
        endcase
    end

    // ---- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            off_reg <= '0;
            slope_reg <= '0;
            iter_reg <= '0;
            div_second_reg <= 1'b0;
            done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            off_reg <= off_next;
            slope_reg <= slope_next;
            iter_reg <= iter_next;
            out_valid_reg <= (state_next == ST_OUT);
            // divider sequencing: done_reg marks a launched divide; the first
            // quotient goes to d0, then the second divide runs for d1
            if (state_reg != ST_DIV)
            begin
                div_second_reg <= 1'b0;
                done_reg <= 1'b0;
            end
            else if (div_start)
            begin
                done_reg <= 1'b1;
            end
            else if (!div_ctrl.busy && done_reg && !div_second_reg)
            begin
                div_second_reg <= 1'b1;
                done_reg <= 1'b0;
            end
        end
    end

    // ---- payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        acc_e_reg <= acc_e_next;
        acc_g_reg <= acc_g_next;
        esum_reg <= esum_next;
        case (state_reg)
            ST_MUL1:
            begin
                xh_reg <= rd_x;
                yh_reg <= rd_y;
                prod_reg <= 64'(slope_reg) * 64'(rd_x);
            end
            ST_PRED:
                err_reg <= sat32(pred - 64'(yh_reg));
            ST_MUL2:
                prod_reg <= 64'(err_reg) * 64'(xh_reg);
            ST_STEP_MUL:
            begin
                grad_reg <= sat40(acc_g_reg);
                stp_e_reg <= $signed({1'b0, rate_reg}) * sat40(acc_e_reg);
            end
            ST_DIV:
            begin
                stp_g_reg <= $signed({1'b0, rate_reg}) * grad_reg;
                if (!div_ctrl.busy && done_reg && !div_second_reg)
                    d0_reg <= stp_e_reg[63] ? -$signed(div_quot) : $signed(div_quot);
            end
            default: ;
        endcase
    end

    assign res.valid = out_valid_reg;
    assign res.fit_offset = off_reg;
    assign res.fit_slope = slope_reg;
    assign res.final_error = esum_reg;
    assign res.iterations_used = iter_reg;

    `LFGD_ASSERT_IMP(a_no_load_when_busy, state_reg != ST_LOAD, !pts.ready,
        "point input ready while fitting")
    `LFGD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNTW'(MAX_POINTS),
        "point count beyond store depth")
    `LFGD_ASSERT_NEXT(a_out_clears, res.valid && res.ready, count_reg == '0,
        "point count not cleared after result")
endmodule
